[rtl/cfu16_pkg.sv]
// Shared types, constants and float helpers for the complex float to u16 converter.
package cfu16_pkg;

   localparam int unsigned STAGES = 10;
   localparam int unsigned OUT_W  = 16;

   localparam logic [31:0] F_QNAN    = 32'h7FC0_0000;
   localparam logic [30:0] F_INF_MAG = 31'h7F80_0000;

   typedef struct packed {
      logic [31:0] real_bits;
      logic [31:0] imag_bits;
      logic        last_in;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] real_out;
      logic [OUT_W-1:0] imag_out;
      logic             last_out;
   } rsp_type;

   typedef enum logic [1:0] {
      CSR_SCALE = 2'd0,
      CSR_BIAS  = 2'd1,
      CSR_ROUND = 2'd2,
      CSR_SAT   = 2'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      RND_ZERO    = 2'd0,
      RND_NEAREST = 2'd1,
      RND_UP      = 2'd2,
      RND_DOWN    = 2'd3
   } rnd_type;

   typedef struct packed {
      logic [31:0] scale;
      logic [31:0] bias;
      rnd_type     round_mode;
      logic        saturate_mode;
   } cfg_type;

   // leading zeros of a 48-bit word, 48 when zero
   function automatic logic [5:0] lzc48(input logic [47:0] m);
      logic [5:0] n;
      n = 6'd48;
      for (int i = 0; i < 48; i++) begin
         if (m[i]) begin
            n = 6'(47 - i);
         end
      end
      return n;
   endfunction

   // m normalized (msb at bit 47) or zero; be is the biased exponent of the msb
   function automatic logic [31:0] round_pack(input logic sgn, input logic [47:0] m,
                                              input logic signed [9:0] be);
      logic [5:0]  sh;
      logic [47:0] ms;
      logic        stk;
      logic [23:0] sig;
      logic        inc;
      logic [7:0]  ef;
      logic [30:0] mag;
      logic [31:0] res;
      sh  = 6'd0;
      ms  = m;
      stk = 1'b0;
      ef  = 8'd0;
      if (be < 10'sd1) begin
         if (be < -10'sd62) begin
            sh = 6'd63;
         end else begin
            sh = 6'(10'sd1 - be);
         end
         ms  = m >> sh;
         stk = |(m & ~({48{1'b1}} << sh));
      end else begin
         ef = 8'(be - 10'sd1);
      end
      sig = ms[47:24];
      inc = ms[23] & (stk | (|ms[22:0]) | sig[0]);
      mag = {ef, 23'd0} + {7'd0, sig} + {30'd0, inc};
      if (m == 48'd0) begin
         res = {sgn, 31'd0};
      end else if (be > 10'sd254) begin
         res = {sgn, F_INF_MAG};
      end else begin
         res = {sgn, mag};
      end
      return res;
   endfunction

endpackage

[rtl/cfu16_lane.sv]
// One part's datapath: float multiply, float add, then integer rounding and 16-bit step.
module cfu16_lane (
   input  logic                         clock,
   input  logic [cfu16_pkg::STAGES:1]   en,
   input  cfu16_pkg::cfg_type           cfg,
   input  logic [31:0]                  x_bits,
   output logic [cfu16_pkg::OUT_W-1:0]  y
);

   // stage 1: operand unpack and significand product
   logic [7:0]  s_e, x_e;
   logic [22:0] s_m, x_m;
   logic        s_nan, s_inf, s_zero, x_nan, x_inf, x_zero;
   logic [23:0] s_sig, x_sig;
   logic [7:0]  s_ee, x_ee;
   logic [47:0] p1_in;
   logic signed [9:0] k1_in;

   logic [47:0] p1_ff;
   logic signed [9:0] k1_ff;
   logic        sgn1_ff, nan1_ff, inf1_ff;

   always_comb begin
      s_e    = cfg.scale[30:23];
      s_m    = cfg.scale[22:0];
      x_e    = x_bits[30:23];
      x_m    = x_bits[22:0];
      s_nan  = (&s_e) & (|s_m);
      s_inf  = (&s_e) & ~(|s_m);
      s_zero = (s_e == 8'd0) & (s_m == 23'd0);
      x_nan  = (&x_e) & (|x_m);
      x_inf  = (&x_e) & ~(|x_m);
      x_zero = (x_e == 8'd0) & (x_m == 23'd0);
      s_sig  = {s_e != 8'd0, s_m};
      x_sig  = {x_e != 8'd0, x_m};
      s_ee   = (s_e == 8'd0) ? 8'd1 : s_e;
      x_ee   = (x_e == 8'd0) ? 8'd1 : x_e;
      p1_in  = s_sig * x_sig;
      k1_in  = $signed({2'b00, s_ee}) + $signed({2'b00, x_ee}) - 10'sd126;
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         p1_ff   <= p1_in;
         k1_ff   <= k1_in;
         sgn1_ff <= cfg.scale[31] ^ x_bits[31];
         nan1_ff <= s_nan | x_nan | (s_inf & x_zero) | (x_inf & s_zero);
         inf1_ff <= s_inf | x_inf;
      end
   end

   // stage 2: leading zero count of the product
   logic [47:0] p2_ff;
   logic [5:0]  lz2_ff;
   logic signed [9:0] k2_ff;
   logic        sgn2_ff, nan2_ff, inf2_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         p2_ff   <= p1_ff;
         lz2_ff  <= cfu16_pkg::lzc48(p1_ff);
         k2_ff   <= k1_ff;
         sgn2_ff <= sgn1_ff;
         nan2_ff <= nan1_ff;
         inf2_ff <= inf1_ff;
      end
   end

   // stage 3: normalize the product
   logic [47:0] m3_ff;
   logic signed [9:0] be3_ff;
   logic        sgn3_ff, nan3_ff, inf3_ff;

   always_ff @(posedge clock) begin
      if (en[3]) begin
         m3_ff   <= p2_ff << lz2_ff;
         be3_ff  <= k2_ff - $signed({4'b0000, lz2_ff});
         sgn3_ff <= sgn2_ff;
         nan3_ff <= nan2_ff;
         inf3_ff <= inf2_ff;
      end
   end

   // stage 4: round the product to single
   logic [31:0] prod4_in, prod4_ff;

   always_comb begin
      if (nan3_ff) begin
         prod4_in = cfu16_pkg::F_QNAN;
      end else if (inf3_ff) begin
         prod4_in = {sgn3_ff, cfu16_pkg::F_INF_MAG};
      end else begin
         prod4_in = cfu16_pkg::round_pack(sgn3_ff, m3_ff, be3_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         prod4_ff <= prod4_in;
      end
   end

   // stage 5: add operand order and alignment
   logic [31:0] big, sml;
   logic [7:0]  a_e, b_e, big_e, sml_e, d;
   logic        a_nan, a_inf, b_nan, b_inf;
   logic [26:0] big27, sml27, sml_sh;
   logic        sml_stk;

   logic [26:0] a5_ff, b5_ff;
   logic        sub5_ff, sgn5_ff, nan5_ff, inf5_ff, isgn5_ff;
   logic signed [9:0] k5_ff;

   always_comb begin
      a_e   = prod4_ff[30:23];
      b_e   = cfg.bias[30:23];
      a_nan = (&a_e) & (|prod4_ff[22:0]);
      a_inf = (&a_e) & ~(|prod4_ff[22:0]);
      b_nan = (&b_e) & (|cfg.bias[22:0]);
      b_inf = (&b_e) & ~(|cfg.bias[22:0]);
      if (prod4_ff[30:0] >= cfg.bias[30:0]) begin
         big = prod4_ff;
         sml = cfg.bias;
      end else begin
         big = cfg.bias;
         sml = prod4_ff;
      end
      big_e   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      sml_e   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
      d       = big_e - sml_e;
      big27   = {big[30:23] != 8'd0, big[22:0], 3'b000};
      sml27   = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
      sml_sh  = sml27 >> d;
      sml_stk = |(sml27 & ~({27{1'b1}} << d));
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         a5_ff    <= big27;
         b5_ff    <= {sml_sh[26:1], sml_sh[0] | sml_stk};
         sub5_ff  <= big[31] ^ sml[31];
         sgn5_ff  <= big[31];
         k5_ff    <= $signed({2'b00, big_e}) + 10'sd1;
         nan5_ff  <= a_nan | b_nan | (a_inf & b_inf & (prod4_ff[31] != cfg.bias[31]));
         inf5_ff  <= a_inf | b_inf;
         isgn5_ff <= a_inf ? prod4_ff[31] : cfg.bias[31];
      end
   end

   // stage 6: add or subtract magnitudes
   logic [27:0] s6_in;
   logic [47:0] m6_ff;
   logic signed [9:0] k6_ff;
   logic        sgn6_ff, nan6_ff, inf6_ff, isgn6_ff;

   always_comb begin
      if (sub5_ff) begin
         s6_in = {1'b0, a5_ff} - {1'b0, b5_ff};
      end else begin
         s6_in = {1'b0, a5_ff} + {1'b0, b5_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         m6_ff    <= {s6_in, 20'd0};
         k6_ff    <= k5_ff;
         sgn6_ff  <= sgn5_ff;
         nan6_ff  <= nan5_ff;
         inf6_ff  <= inf5_ff;
         isgn6_ff <= isgn5_ff;
      end
   end

   // stage 7: leading zero count of the sum
   logic [47:0] m7_ff;
   logic [5:0]  lz7_ff;
   logic signed [9:0] k7_ff;
   logic        sgn7_ff, nan7_ff, inf7_ff, isgn7_ff;

   always_ff @(posedge clock) begin
      if (en[7]) begin
         m7_ff    <= m6_ff;
         lz7_ff   <= cfu16_pkg::lzc48(m6_ff);
         k7_ff    <= k6_ff;
         sgn7_ff  <= sgn6_ff;
         nan7_ff  <= nan6_ff;
         inf7_ff  <= inf6_ff;
         isgn7_ff <= isgn6_ff;
      end
   end

   // stage 8: normalize the sum
   logic [47:0] m8_ff;
   logic signed [9:0] be8_ff;
   logic        sgn8_ff, nan8_ff, inf8_ff, isgn8_ff;

   always_ff @(posedge clock) begin
      if (en[8]) begin
         m8_ff    <= m7_ff << lz7_ff;
         be8_ff   <= k7_ff - $signed({4'b0000, lz7_ff});
         sgn8_ff  <= sgn7_ff;
         nan8_ff  <= nan7_ff;
         inf8_ff  <= inf7_ff;
         isgn8_ff <= isgn7_ff;
      end
   end

   // stage 9: round the sum to single
   logic [31:0] f9_in, f9_ff;

   always_comb begin
      if (nan8_ff) begin
         f9_in = cfu16_pkg::F_QNAN;
      end else if (inf8_ff) begin
         f9_in = {isgn8_ff, cfu16_pkg::F_INF_MAG};
      end else begin
         f9_in = cfu16_pkg::round_pack(sgn8_ff, m8_ff, be8_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en[9]) begin
         f9_ff <= f9_in;
      end
   end

   // stage 10: clamp, integer rounding, 16-bit step
   logic [7:0]  f_e;
   logic [24:0] f_sig;
   logic [4:0]  r;
   logic [31:0] t;
   logic        half, any;
   logic [cfu16_pkg::OUT_W-1:0] y10_in, y10_ff;

   always_comb begin
      f_e   = f9_ff[30:23];
      f_sig = {1'b0, f_e != 8'd0, f9_ff[22:0]};
      r     = 5'd0;
      half  = 1'b0;
      any   = 1'b0;
      t     = 32'd0;
      if ((&f_e) & (|f9_ff[22:0])) begin
         t = 32'd0;
      end else if (f9_ff[31]) begin
         t = 32'd0;
      end else if (f_e >= 8'd159) begin
         t = 32'hFFFF_FFFF;
      end else if (f_e >= 8'd150) begin
         t = {7'd0, f_sig} << (f_e - 8'd150);
      end else begin
         if (f_e < 8'd125) begin
            r = 5'd25;
         end else begin
            r = 5'(8'd150 - f_e);
         end
         t    = {7'd0, f_sig >> r};
         half = f_sig[r - 5'd1];
         any  = |(f_sig & ~({25{1'b1}} << r));
         case (cfg.round_mode)
            cfu16_pkg::RND_NEAREST: t = t + {31'd0, half};
            cfu16_pkg::RND_UP:      t = t + {31'd0, any};
            default:                t = t;
         endcase
      end
      if (cfg.saturate_mode && (t[31:cfu16_pkg::OUT_W] != '0)) begin
         y10_in = '1;
      end else begin
         y10_in = t[cfu16_pkg::OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[10]) begin
         y10_ff <= y10_in;
      end
   end

   assign y = y10_ff;

endmodule

[rtl/complex_float_to_u16_convert.sv]
// Top level: complex single-precision to u16 converter with scale, bias and rounding control.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  req_data  (real_bits, imag_bits, last_in)
//   rsp_     out        rsp_valid/rsp_stall  rsp_data  (real_out, imag_out, last_out)
//   csr_     in         csr_valid/csr_ready  csr_index, csr_wdata
//
// Ten register stages per item; one item per cycle sustained while rsp_stall is low.
// The two parts run in separate lanes: multiply, round, align, add, round, convert.
// Each stage advances when it is empty or the stage after it advances, so bubbles close up.
// Reset clears the stage valids and loads the configuration registers with their defaults.
// csr_ready is always high.
module complex_float_to_u16_convert (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  cfu16_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output cfu16_pkg::rsp_type  rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_wdata
);

   localparam int unsigned N = cfu16_pkg::STAGES;

   cfu16_pkg::cfg_type cfg_ff;
   logic [N:1]   v_ff;
   logic [N:1]   last_ff;
   logic [N+1:1] rdy;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale         <= 32'h3F80_0000;
         cfg_ff.bias          <= 32'd0;
         cfg_ff.round_mode    <= cfu16_pkg::RND_ZERO;
         cfg_ff.saturate_mode <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (cfu16_pkg::csr_idx_type'(csr_index))
            cfu16_pkg::CSR_SCALE: cfg_ff.scale         <= csr_wdata;
            cfu16_pkg::CSR_BIAS:  cfg_ff.bias          <= csr_wdata;
            cfu16_pkg::CSR_ROUND: cfg_ff.round_mode    <= cfu16_pkg::rnd_type'(csr_wdata[1:0]);
            cfu16_pkg::CSR_SAT:   cfg_ff.saturate_mode <= csr_wdata[0];
            default:              cfg_ff               <= cfg_ff;
         endcase
      end
   end

   always_comb begin
      rdy[N+1] = ~rsp_stall;
      for (int i = N; i >= 1; i--) begin
         rdy[i] = ~v_ff[i] | rdy[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[1]) begin
            v_ff[1] <= req_valid;
         end
         for (int i = 2; i <= N; i++) begin
            if (rdy[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         last_ff[1] <= req_data.last_in;
      end
      for (int i = 2; i <= N; i++) begin
         if (rdy[i]) begin
            last_ff[i] <= last_ff[i-1];
         end
      end
   end

   cfu16_lane u_real (
      .clock  (clock),
      .en     (rdy[N:1]),
      .cfg    (cfg_ff),
      .x_bits (req_data.real_bits),
      .y      (rsp_data.real_out)
   );

   cfu16_lane u_imag (
      .clock  (clock),
      .en     (rdy[N:1]),
      .cfg    (cfg_ff),
      .x_bits (req_data.imag_bits),
      .y      (rsp_data.imag_out)
   );

   assign req_stall         = ~rdy[1];
   assign rsp_valid         = v_ff[N];
   assign rsp_data.last_out = last_ff[N];

endmodule

[dv/tb_top.sv]
// Testbench for complex_float_to_u16_convert: directed and random items checked against a predictor.
`timescale 1ns / 1ps

module tb_top;

   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int unsigned RANDOM_ITEMS = 1820;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   cfu16_pkg::req_type    req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   cfu16_pkg::rsp_type    rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [1:0]            csr_index = '0;
   logic [31:0]           csr_wdata = '0;

   cfu16_pkg::cfg_type    model_cfg;
   cfu16_pkg::rsp_type    pending_rsp[$];
   int unsigned           mismatches = 0;
   int unsigned           cycles = 0;
   bit                    quiet = 1'b0;

   complex_float_to_u16_convert uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit take_break();
      return !quiet && ($urandom_range(99) < 23);
   endfunction

   // single-precision pattern to its exact double value
   function automatic real f32_value(input logic [31:0] b);
      logic [63:0] d;
      if (b[30:23] == 8'hFF) begin
         d = {b[31], 11'h7FF, b[22:0], 29'd0};
      end else if (b[30:23] == 8'h00) begin
         return (b[31] ? -1.0 : 1.0) * real'(b[22:0]) * (2.0 ** (-149));
      end else begin
         d = {b[31], 11'(b[30:23] + 11'd896), b[22:0], 29'd0};
      end
      return $bitstoreal(d);
   endfunction

   // double to single precision, round to nearest even, with subnormals
   function automatic logic [31:0] f32_round(input real r);
      logic [63:0] d;
      logic [63:0] m;
      logic [63:0] sig;
      logic [63:0] rem;
      logic [63:0] half;
      logic [63:0] mag;
      int          be;
      int          n;
      int          ebase;
      d = $realtobits(r);
      if (d[62:52] == 11'h7FF) begin
         return (d[51:0] != 0) ? 32'h7FC0_0000 : {d[63], 31'h7F80_0000};
      end
      if (d[62:52] == 11'h000) begin
         return {d[63], 31'd0};
      end
      m = {11'd0, 1'b1, d[51:0]};
      be = int'(d[62:52]) - 896;
      n = (be >= 1) ? 29 : 30 - be;
      ebase = (be >= 1) ? be - 1 : 0;
      if (n >= 60) begin
         sig = 64'd0;
      end else begin
         sig = m >> n;
         rem = m & ((64'd1 << n) - 64'd1);
         half = 64'd1 << (n - 1);
         if (rem > half || (rem == half && sig[0])) begin
            sig = sig + 64'd1;
         end
      end
      mag = (64'(ebase) << 23) + sig;
      if (mag >= 64'h7F80_0000) begin
         return {d[63], 31'h7F80_0000};
      end
      return {d[63], mag[30:0]};
   endfunction

   function automatic logic [15:0] to_u16(input logic [31:0] x);
      logic [31:0] prod;
      logic [31:0] sum;
      logic [23:0] sig;
      logic [63:0] t;
      logic [63:0] rem;
      bit          near;
      bit          up;
      int          sh;
      prod = f32_round(f32_value(model_cfg.scale) * f32_value(x));
      sum = f32_round(f32_value(prod) + f32_value(model_cfg.bias));
      near = 1'b0;
      up = 1'b0;
      if (sum[30:23] == 8'hFF && sum[22:0] != 0) begin
         t = 64'd0;
      end else if (sum[31]) begin
         t = 64'd0;
      end else if (sum[30:23] >= 8'd159) begin
         t = 64'hFFFF_FFFF;
      end else begin
         sig = (sum[30:23] == 8'd0) ? {1'b0, sum[22:0]} : {1'b1, sum[22:0]};
         sh = 150 - ((sum[30:23] == 8'd0) ? 1 : int'(sum[30:23]));
         if (sh <= 0) begin
            t = 64'(sig) << (-sh);
         end else if (sh > 40) begin
            t = 64'd0;
            up = (sig != 0);
         end else begin
            t = 64'(sig) >> sh;
            rem = 64'(sig) & ((64'd1 << sh) - 64'd1);
            near = (rem >= (64'd1 << (sh - 1)));
            up = (rem != 0);
         end
         if (model_cfg.round_mode == cfu16_pkg::RND_NEAREST && near) t = t + 64'd1;
         if (model_cfg.round_mode == cfu16_pkg::RND_UP && up) t = t + 64'd1;
      end
      if (model_cfg.saturate_mode && t > 64'hFFFF) begin
         t = 64'hFFFF;
      end
      return t[15:0];
   endfunction

   task automatic send_item(input cfu16_pkg::req_type d);
      cfu16_pkg::rsp_type e;
      while (take_break()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= d;
      do @(posedge clock); while (req_stall);
      e.real_out = to_u16(d.real_bits);
      e.imag_out = to_u16(d.imag_bits);
      e.last_out = d.last_in;
      pending_rsp.push_back(e);
   endtask

   task automatic send_pair(input logic [31:0] re, input logic [31:0] im);
      cfu16_pkg::req_type d;
      d.real_bits = re;
      d.imag_bits = im;
      d.last_in = 1'($urandom_range(1));
      send_item(d);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (cfu16_pkg::STAGES + 4) @(posedge clock);
   endtask

   // leaves csr_valid high; the caller drops it after the last write
   task automatic write_csr(input cfu16_pkg::csr_idx_type idx, input logic [31:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         cfu16_pkg::CSR_SCALE: model_cfg.scale = v;
         cfu16_pkg::CSR_BIAS:  model_cfg.bias = v;
         cfu16_pkg::CSR_ROUND: model_cfg.round_mode = cfu16_pkg::rnd_type'(v[1:0]);
         default:              model_cfg.saturate_mode = v[0];
      endcase
   endtask

   task automatic set_config(input logic [31:0] sc, input logic [31:0] bi,
                             input cfu16_pkg::rnd_type rm, input logic sat);
      drain();
      write_csr(cfu16_pkg::CSR_SCALE, sc);
      write_csr(cfu16_pkg::CSR_BIAS, bi);
      write_csr(cfu16_pkg::CSR_ROUND, 32'(rm));
      write_csr(cfu16_pkg::CSR_SAT, {31'($urandom_range(32'h7FFF_FFFF)), sat});
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] rand_float();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(9))
         0, 1, 2: ;
         3, 4, 5: r = {($urandom_range(9) == 0), 8'($urandom_range(120, 160)), r[22:0]};
         6: r = {1'b0, 8'($urandom_range(126, 143)), r[22:0] & 23'h7F_FC00};
         7: r = {r[31], 8'hFF, (r[0] ? 23'd0 : r[22:0])};
         8: r = {r[31], 8'($urandom_range(0, 2)), r[22:0]};
         default: r = {1'b0, 8'($urandom_range(140, 160)), r[22:0]};
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      cfu16_pkg::rsp_type e;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) $display("unexpected item %h", rsp_data);
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_data.real_out !== e.real_out || rsp_data.imag_out !== e.imag_out ||
                rsp_data.last_out !== e.last_out) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10) begin
                  $display("mismatch: expected %h %h %b, got %h %h %b",
                           e.real_out, e.imag_out, e.last_out,
                           rsp_data.real_out, rsp_data.imag_out, rsp_data.last_out);
               end
            end
         end
      end
      rsp_stall <= take_break();
   end

   task automatic test_defaults();
      send_pair(32'h4120_0000, 32'h0000_0000);
      send_pair(32'h477F_FF00, 32'h3F80_0000);
   endtask

   task automatic test_special_values();
      logic [31:0] v[16];
      v = '{32'h0000_0000, 32'h8000_0000, 32'h7FC0_0000, 32'h7F80_0000,
            32'hFF80_0000, 32'h477F_FF00, 32'h4780_0000, 32'h4F80_0000,
            32'h4F7F_FFFF, 32'h0000_0001, 32'h7F7F_FFFF, 32'hFFFF_FFFF,
            32'hBF00_0000, 32'h4780_0080, 32'h5080_0000, 32'hFFC0_0001};
      set_config(32'h3F80_0000, 32'h0000_0000, cfu16_pkg::RND_ZERO, 1'b0);
      for (int i = 0; i < 8; i++) send_pair(v[i], v[15 - i]);
   endtask

   task automatic test_round_modes();
      for (int m = 0; m < 4; m++) begin
         for (int s = 0; s < 2; s++) begin
            set_config(32'h3F80_0000, 32'h0000_0000, cfu16_pkg::rnd_type'(m), s[0]);
            send_pair(32'h3F00_0000, 32'h3FC0_0000);
            send_pair(32'h4020_0000, 32'h477F_FF80);
         end
      end
   endtask

   task automatic test_random();
      logic [31:0] scales[10];
      logic [31:0] biases[10];
      int          per;
      scales = '{32'h3F80_0000, 32'h0000_0000, 32'h0000_0001, 32'h7F7F_FFFF,
                 32'hFFFF_FFFF, 32'h8000_0000, 32'hBF80_0000, 32'h4780_0000, 0, 0};
      biases = '{32'h0000_0000, 32'h3F00_0000, 32'h4F80_0000, 32'hCF00_0000,
                 32'h7FC0_0001, 32'h7F80_0000, 32'h4780_0000, 32'hFFFF_FFFF, 0, 0};
      per = RANDOM_ITEMS / 20;
      for (int p = 0; p < 20; p++) begin
         logic [31:0] sc;
         logic [31:0] bi;
         sc = (p < 8) ? scales[p] : {1'($urandom_range(1)), 8'($urandom_range(118, 136)),
                                     23'($urandom)};
         bi = (p < 8) ? biases[p] : ((p % 3 == 0) ? $urandom :
                                     {1'b0, 8'($urandom_range(0, 150)), 23'($urandom)});
         set_config(sc, bi, cfu16_pkg::rnd_type'(p % 4), p[2]);
         quiet = (p == 9);
         for (int i = 0; i < per; i++) begin
            cfu16_pkg::req_type d;
            d.real_bits = rand_float();
            d.imag_bits = rand_float();
            d.last_in = ($urandom_range(7) == 0);
            send_item(d);
         end
         quiet = 1'b0;
      end
   endtask

   initial begin
      model_cfg.scale = 32'h3F80_0000;
      model_cfg.bias = 32'h0;
      model_cfg.round_mode = cfu16_pkg::RND_ZERO;
      model_cfg.saturate_mode = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_defaults();
      test_special_values();
      test_round_modes();
      test_random();
      drain();
      mismatches = mismatches + pending_rsp.size();
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
